// ===== rtl/core/gud_pkg.sv =====
// Shared types, constants and address helper for the grid upscale/dilate block.
`timescale 1ns / 1ps
`default_nettype none

package gud_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic signed [7:0] t_cell;
    typedef logic [AW-1:0]     t_addr;

    // per-offset neighbor info; index 0/1/2 = offset -1/0/+1
    // sel: 0 picks the lower coarse row/col, 1 the upper one
    typedef struct packed {
        logic [2:0] rsel;
        logic [2:0] rvld;
        logic [2:0] csel;
        logic [2:0] cvld;
    } t_nbr;

    function automatic t_addr cell_addr(input logic [4:0] row, input logic [4:0] col);
        int full;
        full = int'(row) * MAX_COLS + int'(col);
        return t_addr'(full);
    endfunction

    // 0 acts as 1, above the maximum saturates
    function automatic logic [4:0] eff_dim(input logic [4:0] g, input int maxv);
        logic [4:0] r;
        if (g == 5'd0) begin
            r = 5'd1;
        end else if (int'(g) > maxv) begin
            r = 5'(maxv);
        end else begin
            r = g;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gud_store.sv =====
// Coarse cell store: single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module gud_store (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire gud_pkg::t_addr i_addr,
    input  wire gud_pkg::t_cell i_wdata,
    output gud_pkg::t_cell      o_rdata
);

    gud_pkg::t_cell r_mem [gud_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gud_pick.sv =====
// Dilation select: last positive neighbor in row-major order, else the center value.
`timescale 1ns / 1ps
`default_nettype none

module gud_pick (
    input  wire gud_pkg::t_cell i_vals [4],
    input  wire gud_pkg::t_nbr  i_nbr,
    output gud_pkg::t_cell      o_cell
);

    always_comb begin
        gud_pkg::t_cell res;
        gud_pkg::t_cell v;
        res = i_vals[{i_nbr.rsel[1], i_nbr.csel[1]}];
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                v = i_vals[{i_nbr.rsel[dr], i_nbr.csel[dc]}];
                if (i_nbr.rvld[dr] && i_nbr.cvld[dc] && (v > 8'sd0)) begin
                    res = v;
                end
            end
        end
        o_cell = res;
    end

endmodule

`default_nettype wire

// ===== rtl/core/grid_upscale_dilate.sv =====
// Top level: coarse occupancy store with a 4x upscaled, 3x3-dilated read path.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive i_opcode/i_row_addr/i_col_addr/i_cell_in with i_start;
//   a beat is taken on a rising edge with i_start high and o_busy low.
//   Write beat (opcode 0): stores i_cell_in at the coarse row/col in the same
//   edge, no result; out-of-grid writes are dropped. Next beat can follow at once.
//   Read beat (opcode 1): fine row/col of the 4x replicated grid. The 3x3
//   neighborhood covers at most 2x2 coarse cells; these are fetched one per
//   cycle through the single RAM port in S_FETCH, then selected in S_DRAIN.
//   Result (o_cell_out, o_addr_error) shows with o_strobe for one cycle,
//   registered from S_DRAIN. o_busy drops in the strobe cycle, so the
//   next beat can be taken in it, after the four RAM fetches and the select.
//   Out-of-grid read: flagged result (0, error) in the cycle after accept.
//   The receiver cannot stall; each result beat is taken when shown.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 rows, 1 cols)
//   at that edge. The user must write only while idle; the block does not enforce this.
//   Reset (sync, active low): grid 3x3, sequencer idle, no strobe. The cell
//   store is not cleared; reading an unwritten cell gives undefined data.
module grid_upscale_dilate (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_opcode,
    input  wire logic [5:0]        i_row_addr,
    input  wire logic [5:0]        i_col_addr,
    input  wire logic signed [7:0] i_cell_in,
    output logic                   o_strobe,
    output logic signed [7:0]      o_cell_out,
    output logic                   o_addr_error,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [4:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_slot;

    logic [4:0] r_grid_rows;
    logic [4:0] r_grid_cols;

    // latched read context
    logic [4:0]     r_row_lo, r_row_hi, r_col_lo, r_col_hi;
    gud_pkg::t_nbr  r_nbr;
    gud_pkg::t_cell r_vals [3];

    // effective grid, fine bounds
    logic [4:0] eff_rows, eff_cols;
    logic [6:0] fine_rows, fine_cols;
    logic       accept, rd_accept, wr_accept, rd_oob;

    assign eff_rows  = gud_pkg::eff_dim(r_grid_rows, gud_pkg::MAX_ROWS);
    assign eff_cols  = gud_pkg::eff_dim(r_grid_cols, gud_pkg::MAX_COLS);
    assign fine_rows = {eff_rows, 2'b00};
    assign fine_cols = {eff_cols, 2'b00};

    assign o_busy    = (r_state != S_IDLE);
    assign accept    = i_start && !o_busy;
    assign wr_accept = accept && (i_opcode == gud_pkg::OP_WRITE);
    assign rd_accept = accept && (i_opcode == gud_pkg::OP_READ);
    assign rd_oob    = ({1'b0, i_row_addr} >= fine_rows) || ({1'b0, i_col_addr} >= fine_cols);

    // coarse rows/cols spanned by the neighborhood, and per-offset selects
    logic [6:0]    row_p1, col_p1;
    logic [4:0]    row_lo, row_hi, col_lo, col_hi;
    gud_pkg::t_nbr nbr;

    always_comb begin
        row_p1 = {1'b0, i_row_addr} + 7'd1;
        col_p1 = {1'b0, i_col_addr} + 7'd1;
        row_lo = (i_row_addr == 6'd0) ? 5'd0 : {1'b0, 4'((i_row_addr - 6'd1) >> 2)};
        col_lo = (i_col_addr == 6'd0) ? 5'd0 : {1'b0, 4'((i_col_addr - 6'd1) >> 2)};
        row_hi = row_p1[6:2];
        col_hi = col_p1[6:2];
        nbr.rsel[0] = 1'b0;
        nbr.rsel[1] = ({1'b0, i_row_addr[5:2]} != row_lo);
        nbr.rsel[2] = (row_hi != row_lo);
        nbr.csel[0] = 1'b0;
        nbr.csel[1] = ({1'b0, i_col_addr[5:2]} != col_lo);
        nbr.csel[2] = (col_hi != col_lo);
        nbr.rvld[0] = (i_row_addr != 6'd0);
        nbr.rvld[1] = 1'b1;
        nbr.rvld[2] = (row_p1 < fine_rows);
        nbr.cvld[0] = (i_col_addr != 6'd0);
        nbr.cvld[1] = 1'b1;
        nbr.cvld[2] = (col_p1 < fine_cols);
    end

    // RAM port: write straight from the command beat, else fetch slot
    // slot order: (lo,lo) (lo,hi) (hi,lo) (hi,hi)
    logic           ram_we;
    gud_pkg::t_addr ram_addr;
    gud_pkg::t_cell ram_rdata;

    assign ram_we = wr_accept && ({1'b0, i_row_addr} < {2'b00, eff_rows})
                              && ({1'b0, i_col_addr} < {2'b00, eff_cols});

    always_comb begin
        if (r_state == S_FETCH) begin
            ram_addr = gud_pkg::cell_addr(r_slot[1] ? r_row_hi : r_row_lo,
                                          r_slot[0] ? r_col_hi : r_col_lo);
        end else begin
            ram_addr = gud_pkg::cell_addr(i_row_addr[4:0], i_col_addr[4:0]);
        end
    end

    gud_store u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_cell_in),
        .o_rdata (ram_rdata)
    );

    // last fetch arrives in the drain cycle, straight from the RAM
    gud_pkg::t_cell pick_vals [4];
    gud_pkg::t_cell pick_cell;

    assign pick_vals[0] = r_vals[0];
    assign pick_vals[1] = r_vals[1];
    assign pick_vals[2] = r_vals[2];
    assign pick_vals[3] = ram_rdata;

    gud_pick u_pick (
        .i_vals (pick_vals),
        .i_nbr  (r_nbr),
        .o_cell (pick_cell)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (rd_accept && !rd_oob) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_slot == 2'd3) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= 2'd0;
            o_strobe    <= 1'b0;
            r_grid_rows <= 5'd3;
            r_grid_cols <= 5'd3;
        end else begin
            r_state  <= n_state;
            o_strobe <= (rd_accept && rd_oob) || (r_state == S_DRAIN);
            if (r_state == S_FETCH) begin
                r_slot <= r_slot + 2'd1;
            end else begin
                r_slot <= 2'd0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gud_pkg::CFG_ROWS: r_grid_rows <= i_cfg_data;
                    gud_pkg::CFG_COLS: r_grid_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload: read context, fetched cells, result
    always_ff @(posedge i_clk) begin
        if (rd_accept) begin
            r_row_lo <= row_lo;
            r_row_hi <= row_hi;
            r_col_lo <= col_lo;
            r_col_hi <= col_hi;
            r_nbr    <= nbr;
        end
        if ((r_state == S_FETCH) && (r_slot != 2'd0)) begin
            r_vals[r_slot - 2'd1] <= ram_rdata;
        end
        if (rd_accept && rd_oob) begin
            o_cell_out   <= 8'sd0;
            o_addr_error <= 1'b1;
        end else if (r_state == S_DRAIN) begin
            o_cell_out   <= pick_cell;
            o_addr_error <= 1'b0;
        end
    end

endmodule

`default_nettype wire
